>>> sv/wcu_pkg.sv
package wcu_pkg;

    localparam int MaxColumnsDef = 64;
    localparam int MaxSlicesDef  = 256;

    localparam logic [1:0] CmdLoadThr = 2'd0;
    localparam logic [1:0] CmdWrSpin  = 2'd1;
    localparam logic [1:0] CmdCluster = 2'd2;
    localparam logic [1:0] CmdReseed  = 2'd3;

    localparam logic [1:0] RegColumns  = 2'd0;
    localparam logic [1:0] RegSlices   = 2'd1;
    localparam logic [1:0] RegTempThr  = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  column;
        logic [7:0]  time_slice;
        logic [15:0] threshold;
        logic        spin_up;
        logic [31:0] rng_seed;
    } t_in_word;

    typedef struct packed {
        logic [14:0] cluster_size;
        logic [14:0] up_spins;
    } t_out_word;

    function automatic logic [31:0] xorshift(input logic [31:0] s);
        logic [31:0] x;
        x = s ^ (s << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

endpackage

>>> sv/wcu_ram.sv
module wcu_ram #(
    parameter int Width = 1,
    parameter int Depth = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

>>> sv/wcu_ctrl.sv
module wcu_ctrl
    import wcu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic [1:0] i_cmd,
    input  logic i_in_lattice,
    input  logic i_stack_empty,
    input  logic i_clear_done,
    output logic o_busy,
    output logic o_clear,
    output logic o_latch,
    output logic o_seed,
    output logic o_pop,
    output logic o_addr_nb,
    output logic o_test_nb,
    output logic [1:0] o_nb,
    output logic o_done
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_WRITE, S_SEED, S_POP, S_WAITPOP, S_NBADDR, S_NBWAIT,
        S_NBTEST, S_DONE
    } t_state;

    t_state     r_state;
    logic [1:0] r_nb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_nb    <= '0;
        end else begin
            case (r_state)
                S_CLEAR: if (i_clear_done) r_state <= S_IDLE;
                S_IDLE: if (i_start) begin
                    if (i_cmd == CmdCluster && i_in_lattice) r_state <= S_SEED;
                    else r_state <= S_WRITE;
                end
                // old spin comes back here, spin write and up count settle
                S_WRITE: r_state <= S_DONE;
                S_SEED: r_state <= S_POP;
                S_POP: begin
                    if (i_stack_empty) r_state <= S_DONE;
                    else r_state <= S_WAITPOP;
                end
                S_WAITPOP: begin
                    r_nb    <= '0;
                    r_state <= S_NBADDR;
                end
                S_NBADDR: r_state <= S_NBWAIT;
                S_NBWAIT: r_state <= S_NBTEST;
                S_NBTEST: begin
                    r_nb    <= r_nb + 2'd1;
                    r_state <= (r_nb == 2'd3) ? S_POP : S_NBADDR;
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_clear   = (r_state == S_CLEAR);
    assign o_latch   = (r_state == S_IDLE) && i_start;
    assign o_seed    = (r_state == S_SEED);
    assign o_pop     = (r_state == S_POP) && !i_stack_empty;
    // neighbor register loads in S_NBADDR, its spin read goes out in S_NBWAIT
    assign o_addr_nb = (r_state == S_NBWAIT);
    assign o_test_nb = (r_state == S_NBTEST);
    assign o_nb      = r_nb;
    assign o_done    = (r_state == S_DONE);
endmodule

>>> sv/wcu_dp.sv
module wcu_dp
    import wcu_pkg::*;
#(
    parameter int MaxColumns = MaxColumnsDef,
    parameter int MaxSlices  = MaxSlicesDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in,
    input  logic [6:0]  i_ncol_raw,
    input  logic [8:0]  i_nsl_raw,
    input  logic [15:0] i_tthr,
    input  logic i_clear,
    input  logic i_latch,
    input  logic i_seed,
    input  logic i_pop,
    input  logic i_addr_nb,
    input  logic i_test_nb,
    input  logic [1:0] i_nb,
    output logic o_in_lattice,
    output logic o_stack_empty,
    output logic o_clear_done,
    output t_out_word o_out
);
    localparam int CW = $clog2(MaxColumns);
    localparam int TW = $clog2(MaxSlices);
    localparam int AW = CW + TW;
    localparam int Sites = MaxColumns * MaxSlices;
    localparam int NW = $clog2(Sites + 1);

    logic [CW:0] ncol;
    logic [TW:0] nsl;
    always_comb begin
        if ({25'd0, i_ncol_raw} < 32'd2) ncol = (CW+1)'(2);
        else if ({25'd0, i_ncol_raw} > 32'(MaxColumns)) ncol = (CW+1)'(MaxColumns);
        else ncol = (CW+1)'(i_ncol_raw);
        if ({23'd0, i_nsl_raw} < 32'd2) nsl = (TW+1)'(2);
        else if ({23'd0, i_nsl_raw} > 32'(MaxSlices)) nsl = (TW+1)'(MaxSlices);
        else nsl = (TW+1)'(i_nsl_raw);
    end

    assign o_in_lattice = ({{(32-6){1'b0}}, i_in.column} < 32'(ncol))
                       && ({{(32-8){1'b0}}, i_in.time_slice} < 32'(nsl));

    // spin store, one clear sweep after reset
    logic          sp_we, sp_wd, sp_rd;
    logic [AW-1:0] sp_wa, sp_ra;
    logic [AW:0]   r_clr;
    wcu_ram #(.Width(1), .Depth(Sites)) u_spin (
        .i_clk(i_clk), .i_we(sp_we), .i_waddr(sp_wa), .i_wdata(sp_wd),
        .i_raddr(sp_ra), .o_rdata(sp_rd));

    logic          st_we;
    logic [AW-1:0] st_wa, st_wd, st_ra, st_rd;
    wcu_ram #(.Width(AW), .Depth(Sites)) u_stack (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_wa), .i_wdata(st_wd),
        .i_raddr(st_ra), .o_rdata(st_rd));

    // column bond thresholds, zeroed by the same sweep
    logic          ct_we;
    logic [CW-1:0] ct_wa, ct_ra;
    logic [15:0]   ct_wd, ct_rd;
    wcu_ram #(.Width(16), .Depth(MaxColumns)) u_cthr (
        .i_clk(i_clk), .i_we(ct_we), .i_waddr(ct_wa), .i_wdata(ct_wd),
        .i_raddr(ct_ra), .o_rdata(ct_rd));

    logic [31:0] r_rng;
    logic [NW-1:0] r_up, r_size, r_sp;
    t_in_word    r_in;
    logic        r_old;
    logic        r_wr_pend;
    logic        r_popped;
    logic [CW-1:0] r_c, r_nc;
    logic [TW-1:0] r_t, r_nt;
    logic [15:0]   nthr;
    logic [31:0]   rng_next;

    assign o_clear_done = (r_clr == (AW+1)'(Sites - 1));
    assign o_stack_empty = (r_sp == '0);
    assign rng_next = xorshift(r_rng);

    logic [CW-1:0] cp, cm;
    logic [TW-1:0] tp, tm;
    always_comb begin
        cp = ({1'b0, r_c} + 1'b1 >= ncol) ? '0 : r_c + 1'b1;
        cm = (r_c == '0) ? CW'(ncol - 1'b1) : r_c - 1'b1;
        tp = ({1'b0, r_t} + 1'b1 >= nsl) ? '0 : r_t + 1'b1;
        tm = (r_t == '0) ? TW'(nsl - 1'b1) : r_t - 1'b1;
    end

    // right bond belongs to this column, left bond to the column before
    assign ct_ra = (i_nb == 2'd0) ? r_c : cm;
    assign nthr  = i_nb[1] ? i_tthr : ct_rd;

    logic join_nb;
    assign join_nb = i_test_nb && (sp_rd == r_old) && (rng_next[31:16] < nthr);

    logic [CW-1:0] in_c;
    logic [TW-1:0] in_t;
    logic          thr_col_ok;
    assign in_c = CW'(i_in.column);
    assign in_t = TW'(i_in.time_slice);
    assign thr_col_ok = ({{(32-6){1'b0}}, i_in.column} < 32'(MaxColumns));

    always_comb begin
        ct_we = 1'b0; ct_wa = in_c; ct_wd = i_in.threshold;
        if (i_clear) begin
            ct_we = 1'b1; ct_wa = r_clr[CW-1:0]; ct_wd = '0;
        end else if (i_latch && i_in.cmd == CmdLoadThr && thr_col_ok) begin
            ct_we = 1'b1;
        end
    end

    always_comb begin
        sp_we = 1'b0; sp_wa = {r_c, r_t}; sp_wd = ~r_old;
        sp_ra = {in_c, in_t};
        st_we = 1'b0; st_wa = r_sp[AW-1:0]; st_wd = {r_c, r_t};
        st_ra = AW'(r_sp - 1'b1);
        if (i_clear) begin
            sp_we = 1'b1; sp_wa = r_clr[AW-1:0]; sp_wd = 1'b0;
        end else if (i_seed) begin
            sp_we = 1'b1; sp_wd = ~sp_rd; st_we = 1'b1; st_wa = '0;
        end else if (i_addr_nb) begin
            sp_ra = {r_nc, r_nt};
        end else if (join_nb) begin
            sp_we = 1'b1; sp_wa = {r_nc, r_nt}; st_we = 1'b1; st_wd = {r_nc, r_nt};
        end else if (r_wr_pend) begin
            sp_we = 1'b1; sp_wd = r_in.spin_up;
        end
    end

    // spin write reads the old value first, then writes the new one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0; r_rng <= 32'd1; r_up <= '0; r_sp <= '0;
            r_size <= '0; r_wr_pend <= 1'b0; r_popped <= 1'b0;
        end else begin
            r_wr_pend <= i_latch && (i_in.cmd == CmdWrSpin) && o_in_lattice;
            r_popped  <= i_pop;
            if (i_clear && !o_clear_done) r_clr <= r_clr + 1'b1;
            if (i_latch) begin
                r_in <= i_in; r_size <= '0;
                r_c <= in_c; r_t <= in_t;
                case (i_in.cmd)
                    CmdReseed: r_rng <= (i_in.rng_seed == '0) ? 32'd1 : i_in.rng_seed;
                    default: ;
                endcase
            end
            // popped site lands in the cycle after the pop
            if (r_popped) begin
                r_c <= st_rd[AW-1:TW]; r_t <= st_rd[TW-1:0];
            end
            if (r_wr_pend && sp_rd != r_in.spin_up) begin
                r_up <= r_in.spin_up ? r_up + 1'b1 : r_up - 1'b1;
            end
            if (i_seed) begin
                r_old <= sp_rd; r_sp <= NW'(1); r_size <= NW'(1);
                r_up <= sp_rd ? r_up - 1'b1 : r_up + 1'b1;
            end
            if (i_pop) r_sp <= r_sp - 1'b1;
            if (i_test_nb && sp_rd == r_old) begin
                r_rng <= rng_next;
                if (join_nb) begin
                    r_sp <= r_sp + 1'b1; r_size <= r_size + 1'b1;
                    r_up <= r_old ? r_up - 1'b1 : r_up + 1'b1;
                end
            end
        end
    end

    // neighbor picked while the controller sits in the address-set cycle
    always_ff @(posedge i_clk) begin
        case (i_nb)
            2'd0: begin r_nc <= cp;  r_nt <= r_t; end
            2'd1: begin r_nc <= cm;  r_nt <= r_t; end
            2'd2: begin r_nc <= r_c; r_nt <= tp;  end
            default: begin r_nc <= r_c; r_nt <= tm; end
        endcase
    end

    always_comb begin
        o_out.cluster_size = 15'(r_size);
        o_out.up_spins     = 15'(r_up);
    end
endmodule

>>> sv/wolff_cluster_update_engine_top.sv
// channel  | handshake                      | payload
// cmd in   | i_start / o_busy               | i_in   (t_in_word)
// result   | o_done strobe                  | o_out  (t_out_word)
// config   | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
// after reset the spin store and column thresholds are swept to zero while
// busy stays high
// other commands hold busy through a write state, then the done strobe state
// a cluster update of n sites holds busy through a seed, then per site a pop,
// a wait and four address-wait-test neighbor checks, then a last pop and done
// the result strobe cannot be stalled; config is always ready
module wolff_cluster_update_engine_top
    import wcu_pkg::*;
#(
    parameter int MaxColumns = MaxColumnsDef,
    parameter int MaxSlices  = MaxSlicesDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  t_in_word   i_in,
    output logic       o_done,
    output t_out_word  o_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    logic [6:0]  r_ncol;
    logic [8:0]  r_nsl;
    logic [15:0] r_tthr;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncol <= 7'd64; r_nsl <= 9'd256; r_tthr <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                RegColumns: r_ncol <= i_cfg_data[6:0];
                RegSlices:  r_nsl  <= i_cfg_data[8:0];
                RegTempThr: r_tthr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic in_lat, st_empty, clr_done, clr, latch, seed, pop, anb, tnb;
    logic [1:0] nb;

    wcu_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_cmd(i_in.cmd),
        .i_in_lattice(in_lat), .i_stack_empty(st_empty), .i_clear_done(clr_done),
        .o_busy(o_busy), .o_clear(clr), .o_latch(latch), .o_seed(seed),
        .o_pop(pop), .o_addr_nb(anb), .o_test_nb(tnb), .o_nb(nb), .o_done(o_done));

    wcu_dp #(.MaxColumns(MaxColumns), .MaxSlices(MaxSlices)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in), .i_ncol_raw(r_ncol),
        .i_nsl_raw(r_nsl), .i_tthr(r_tthr), .i_clear(clr), .i_latch(latch),
        .i_seed(seed), .i_pop(pop), .i_addr_nb(anb), .i_test_nb(tnb), .i_nb(nb),
        .o_in_lattice(in_lat), .o_stack_empty(st_empty), .o_clear_done(clr_done),
        .o_out(o_out));

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy) else $error("done while idle");
    a_no_start_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> !o_done) else $error("done too early");
endmodule
